FILE: rtl/mtrt_pkg.sv
// Package for the memory-type reservation table.
// Holds item payload types, op and status codes, table entry and control structs.
// No dependencies.
package mtrt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_PAGE_BYTES  = 4096;

    // Erase match kinds
    localparam logic KIND_EXACT = 1'b0;
    localparam logic KIND_TAIL  = 1'b1;

    // Op codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_NOMATCH  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [51:0] range_start;
        logic [52:0] range_end;
        logic [2:0]  req_type;
        logic        adopt_existing;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  entry_type;
        logic        hit;
        logic [51:0] entry_first;
        logic [52:0] entry_last;
        logic        whole_removed;
    } t_rsp;

    typedef struct packed {
        logic [51:0] first;
        logic [52:0] last;
        logic [2:0]  mtype;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       scan;
        logic       key_sel;
        logic       cp_en;
        logic       wr_new;
        logic       res_load;
        logic [1:0] res_status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       clash;
        logic       lk_found;
        logic       e_pos;
        logic       e_ex;
        logic       e_em;
        logic       out_busy;
    } t_sts;

endpackage

FILE: rtl/mtrt_stream_if.sv
// Valid/ready channel interface carrying one payload item.
// Payload type is set by the instantiating level.
interface mtrt_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/mtrt_datapath.sv
// Datapath: table memory, scan compare logic, request and result registers.
// Depends on mtrt_pkg; driven by mtrt_ctrl.
module mtrt_datapath
    import mtrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  t_req                           i_req,
    output t_sts                           o_sts,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready,
    output t_rsp                           o_rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;
    logic   r_sv, r_sk;
    logic          r_cp_v;
    logic [AW-1:0] r_cp_dst;

    // captured request
    logic [1:0]  r_op;
    logic [51:0] r_s;
    logic [52:0] r_e;
    logic [2:0]  r_rt;
    logic        r_adopt;

    // scan findings
    logic        r_seen, r_clash, r_lk_v, r_ex_v, r_em_v;
    logic [2:0]  r_ft, r_ex_t, r_em_t, r_lk_t;
    logic [51:0] r_fs, r_lk_s;
    logic [52:0] r_lk_e;

    t_rsp r_rsp, n_rsp;
    logic r_ov;

    logic [52:0] hi, pg_end;
    logic [51:0] key;
    logic        ov, e_ex, e_em, e_pos;
    logic [2:0]  ins_type;
    logic        kind;
    t_entry      new_ent;

    // per-entry compare
    assign pg_end   = {1'b0, r_s} + 53'(PAGE_BYTES);
    assign hi       = (r_op == OP_LOOKUP) ? pg_end : r_e;
    assign key      = r_sk ? r_fs : r_s;
    assign ov       = r_sv && ({1'b0, r_rd.first} < hi) && ({1'b0, r_s} < r_rd.last);
    assign e_pos    = r_sv && (r_rd.first > key);
    assign e_ex     = ov && !r_sk && (r_rd.first == r_s) && (r_rd.last == r_e);
    assign e_em     = ov && !r_sk && (r_rd.first < r_s) && (r_rd.last == r_e);
    assign ins_type = r_adopt ? r_ft : r_rt;
    assign kind     = r_ex_v ? KIND_EXACT : KIND_TAIL;

    assign o_sts = '{op: r_op, empty: (r_e <= {1'b0, r_s}), clash: r_clash,
                     lk_found: r_lk_v, e_pos: e_pos, e_ex: e_ex, e_em: e_em,
                     out_busy: r_ov && !i_rsp_ready};

    // new entry: shrunk remainder or inserted range
    always_comb begin
        if (i_cmd.key_sel) begin
            new_ent = '{first: r_fs, last: {1'b0, r_s}, mtype: r_em_t};
        end else begin
            new_ent = '{first: r_s, last: r_e, mtype: ins_type};
        end
    end

    // memory: one registered read, one write
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
        if (r_cp_v) begin
            r_mem[r_cp_dst] <= r_rd;
        end else if (i_cmd.wr_new) begin
            r_mem[i_wr_addr] <= new_ent;
        end
        r_cp_dst <= i_wr_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= 1'b0;
            r_sk   <= 1'b0;
            r_cp_v <= 1'b0;
        end else begin
            r_sv   <= i_cmd.scan;
            r_sk   <= i_cmd.key_sel;
            r_cp_v <= i_cmd.cp_en;
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_req.op;
            r_s     <= i_req.range_start;
            r_e     <= i_req.range_end;
            r_rt    <= i_req.req_type;
            r_adopt <= i_req.adopt_existing;
            r_ft    <= i_req.req_type;
            r_seen  <= 1'b0;
            r_clash <= 1'b0;
            r_lk_v  <= 1'b0;
            r_ex_v  <= 1'b0;
            r_em_v  <= 1'b0;
        end else if (r_sv && !r_sk) begin
            if (ov) begin
                if (!r_seen) begin
                    r_seen <= 1'b1;
                    r_ft   <= r_rd.mtype;
                    if (!r_adopt && r_rd.mtype != r_rt) begin
                        r_clash <= 1'b1;
                    end
                end else if (r_rd.mtype != r_ft) begin
                    r_clash <= 1'b1;
                end
                if (!r_lk_v) begin
                    r_lk_v <= 1'b1;
                    r_lk_s <= r_rd.first;
                    r_lk_e <= r_rd.last;
                    r_lk_t <= r_rd.mtype;
                end
            end
            if (e_ex && !r_ex_v) begin
                r_ex_v <= 1'b1;
                r_ex_t <= r_rd.mtype;
            end
            if (e_em && !r_em_v) begin
                r_em_v <= 1'b1;
                r_fs   <= r_rd.first;
                r_em_t <= r_rd.mtype;
            end
        end
    end

    // result assembly
    always_comb begin
        n_rsp        = '0;
        n_rsp.status = i_cmd.res_status;
        if (i_cmd.res_status == ST_OK) begin
            case (r_op)
                OP_INSERT: begin
                    n_rsp.entry_type = ins_type;
                end
                OP_ERASE: begin
                    n_rsp.entry_type    = r_ex_v ? r_ex_t : r_em_t;
                    n_rsp.hit           = 1'b1;
                    n_rsp.entry_first   = r_ex_v ? r_s : r_fs;
                    n_rsp.entry_last    = r_e;
                    n_rsp.whole_removed = (kind == KIND_EXACT);
                end
                OP_LOOKUP: begin
                    n_rsp.entry_type  = r_lk_t;
                    n_rsp.hit         = 1'b1;
                    n_rsp.entry_first = r_lk_s;
                    n_rsp.entry_last  = r_lk_e;
                end
                default: begin
                    n_rsp = n_rsp;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_ov <= 1'b1;
        end else if (i_rsp_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_rsp_valid = r_ov;
    assign o_rsp       = r_rsp;

endmodule

FILE: rtl/mtrt_ctrl.sv
// Controller: sequences scans, shifts and placement over the table slots.
// Depends on mtrt_pkg; drives mtrt_datapath.
module mtrt_ctrl
    import mtrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  t_sts                           i_sts,
    output t_cmd                           o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_wr_addr
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_SHD   = 4'd3;
    localparam logic [3:0] S_CPD   = 4'd4;
    localparam logic [3:0] S_PLACE = 4'd5;
    localparam logic [3:0] S_SHU   = 4'd6;
    localparam logic [3:0] S_UDR   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count, r_i, n_i, r_ridx, n_ridx;
    logic [CW-1:0] r_pos, n_pos, r_kx, n_kx, r_ke, n_ke;
    logic          r_pos_v, n_pos_v, r_kx_v, n_kx_v, r_ke_v, n_ke_v;
    logic          r_scan2, n_scan2, r_shrink, n_shrink;
    logic [1:0]    r_code, n_code;
    logic [CW-1:0] i_inc, i_dec;

    assign i_inc = r_i + CW'(1);
    assign i_dec = r_i - CW'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_ridx   = r_ridx;
        n_pos    = r_pos;
        n_pos_v  = r_pos_v;
        n_kx     = r_kx;
        n_kx_v   = r_kx_v;
        n_ke     = r_ke;
        n_ke_v   = r_ke_v;
        n_scan2  = r_scan2;
        n_shrink = r_shrink;
        n_code   = r_code;
        o_cmd    = '0;
        o_cmd.res_status = r_code;
        o_cmd.key_sel    = r_scan2;
        o_rd_addr = '0;
        o_wr_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_i      = '0;
                    n_scan2  = 1'b0;
                    n_pos_v  = 1'b0;
                    n_kx_v   = 1'b0;
                    n_ke_v   = 1'b0;
                    n_shrink = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // note first hits of the entry returning this cycle
                if (i_sts.e_pos && !r_pos_v) begin
                    n_pos_v = 1'b1;
                    n_pos   = r_ridx;
                end
                if (i_sts.e_ex && !r_kx_v) begin
                    n_kx_v = 1'b1;
                    n_kx   = r_ridx;
                end
                if (i_sts.e_em && !r_ke_v) begin
                    n_ke_v = 1'b1;
                    n_ke   = r_ridx;
                end
                if (r_i < r_count) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.scan  = 1'b1;
                    o_rd_addr   = r_i[AW-1:0];
                    n_ridx      = r_i;
                    n_i         = i_inc;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_FIN;
                n_code  = ST_NOMATCH;
                if (r_scan2) begin
                    n_code  = ST_OK;
                    n_pos   = r_pos_v ? r_pos : r_count;
                    n_i     = r_count;
                    n_state = S_SHD;
                end else begin
                    case (i_sts.op)
                        OP_INSERT: begin
                            if (i_sts.empty) begin
                                n_code = ST_NOMATCH;
                            end else if (i_sts.clash) begin
                                n_code = ST_CONFLICT;
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                n_code = ST_FULL;
                            end else begin
                                n_code  = ST_OK;
                                n_pos   = r_pos_v ? r_pos : r_count;
                                n_i     = r_count;
                                n_state = S_SHD;
                            end
                        end
                        OP_ERASE: begin
                            if (!i_sts.empty && (r_kx_v || r_ke_v)) begin
                                n_code   = ST_OK;
                                n_i      = r_kx_v ? r_kx : r_ke;
                                n_shrink = !r_kx_v;
                                n_state  = S_SHU;
                            end
                        end
                        OP_LOOKUP: begin
                            n_code = i_sts.lk_found ? ST_OK : ST_NOMATCH;
                        end
                        default: begin
                            n_code = ST_NOMATCH;
                        end
                    endcase
                end
            end
            // open a slot: copy slot i-1 into slot i, from the end down to pos
            S_SHD: begin
                if (r_i > r_pos) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.cp_en = 1'b1;
                    o_rd_addr   = i_dec[AW-1:0];
                    o_wr_addr   = r_i[AW-1:0];
                    n_i         = i_dec;
                end else begin
                    n_state = S_CPD;
                end
            end
            S_CPD: begin
                n_state = S_PLACE;
            end
            S_PLACE: begin
                o_cmd.wr_new = 1'b1;
                o_wr_addr    = r_pos[AW-1:0];
                n_count      = r_count + CW'(1);
                n_state      = S_FIN;
            end
            // close a slot: copy slot i+1 into slot i
            S_SHU: begin
                if (i_inc < r_count) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.cp_en = 1'b1;
                    o_rd_addr   = i_inc[AW-1:0];
                    o_wr_addr   = r_i[AW-1:0];
                    n_i         = i_inc;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_UDR;
                end
            end
            S_UDR: begin
                if (r_shrink) begin
                    n_scan2 = 1'b1;
                    n_i     = '0;
                    n_pos_v = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_i      <= '0;
            r_ridx   <= '0;
            r_pos    <= '0;
            r_pos_v  <= 1'b0;
            r_kx     <= '0;
            r_kx_v   <= 1'b0;
            r_ke     <= '0;
            r_ke_v   <= 1'b0;
            r_scan2  <= 1'b0;
            r_shrink <= 1'b0;
            r_code   <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_i      <= n_i;
            r_ridx   <= n_ridx;
            r_pos    <= n_pos;
            r_pos_v  <= n_pos_v;
            r_kx     <= n_kx;
            r_kx_v   <= n_kx_v;
            r_ke     <= n_ke;
            r_ke_v   <= n_ke_v;
            r_scan2  <= n_scan2;
            r_shrink <= n_shrink;
            r_code   <= n_code;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: rtl/memory_type_reservation_table.sv
// Memory-type reservation table, top level.
// Uses a valid/ready request channel (i_req) and result channel (o_rsp).
// Each request item is insert, erase/shrink or page lookup on the table of
// physical ranges; exactly one result item comes back per request.
// Timing: one item at a time. A request is taken only when the controller is
// idle. Every op scans the stored slots through the single memory read port,
// one slot per cycle. An insert then moves up to count slots one per cycle
// to open a gap; an erase closes the gap the same way, and a shrink adds a
// second scan and a gap opening.
// The result sits in an output register; if the receiver stalls, the next
// finished result waits in the controller until the register is free.
// Reset empties the table at once (fill count cleared); no clearing pass.
// Slots are kept packed and ordered by start, so free slots are never read.
module memory_type_reservation_table
    import mtrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
    input logic i_clk,
    input logic i_rst_n,
    mtrt_stream_if.sink   i_req,
    mtrt_stream_if.source o_rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          in_ready;

    mtrt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    mtrt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .PAGE_BYTES(PAGE_BYTES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .i_req       (i_req.payload),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (o_rsp.payload)
    );

    assign i_req.ready = in_ready;

`ifndef SYNTHESIS
    // not ready again in the cycle after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous item in progress");

    // a hit is only reported with ok status
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.hit) |-> (o_rsp.payload.status == ST_OK))
        else $error("hit reported with failing status");

    // whole removal implies an entry was found
    a_whole_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.whole_removed) |-> o_rsp.payload.hit)
        else $error("whole removal without hit");
`endif

endmodule
